### src/nearest_neighbor_downscaler_defines.svh
// assertion macros shared by the downscaler checker
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define NND_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nnd check failed: same-cycle rule");

// next-cycle implication, disabled while reset is active
`define NND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nnd check failed: next-cycle rule");

`endif

### src/nnd_pkg.sv
// types, constants and codes of the nearest neighbor downscaler
package nnd_pkg;

	localparam int unsigned SIDE_W             = 15;
	localparam int unsigned PIXEL_W            = 32;
	localparam int unsigned PROD_W             = 2 * SIDE_W;
	localparam int unsigned CFG_IDX_W          = 2;
	localparam int unsigned QUEUE_DEPTH        = 4;
	localparam int unsigned MAX_SIDE_LIMIT_DEF = 16384;

	localparam logic [SIDE_W-1:0] RST_SRC_WIDTH  = SIDE_W'(1);
	localparam logic [SIDE_W-1:0] RST_SRC_HEIGHT = SIDE_W'(1);
	localparam logic [SIDE_W-1:0] RST_MAX_SIDE   = SIDE_W'(4096);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH  = 2'd0,
		CFG_SRC_HEIGHT = 2'd1,
		CFG_MAX_SIDE   = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_OW_GO,
		ST_OW_WAIT,
		ST_OH_GO,
		ST_OH_WAIT,
		ST_SW_GO,
		ST_SW_WAIT,
		ST_SH_GO,
		ST_SH_WAIT
	} setup_state_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_in;
		logic               frame_start;
	} in_item_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_out;
		logic               row_end;
		logic               frame_end;
	} out_item_t;

	// frame geometry handed from the setup unit to the classifier
	typedef struct packed {
		logic              restart;
		logic [SIDE_W-1:0] src_w;
		logic [SIDE_W-1:0] src_h;
		logic [SIDE_W-1:0] out_w;
		logic [SIDE_W-1:0] out_h;
		logic [SIDE_W-1:0] col_whole;
		logic [SIDE_W-1:0] col_frac;
		logic [SIDE_W-1:0] row_whole;
		logic [SIDE_W-1:0] row_frac;
	} geom_t;

endpackage

### src/nnd_divider.sv
// restoring divider, one quotient bit per cycle
module nnd_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nnd_pkg::PROD_W-1:0]  dividend,
	input  logic [nnd_pkg::SIDE_W-1:0]  divisor,
	output logic [nnd_pkg::PROD_W-1:0]  quotient,
	output logic [nnd_pkg::SIDE_W-1:0]  remainder,
	output logic                        done
);
	import nnd_pkg::*;

	localparam int unsigned CNT_W = $clog2(PROD_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    count_q;
	logic [PROD_W-1:0]   quo_q;
	logic [SIDE_W-1:0]   rem_q;
	logic [SIDE_W-1:0]   dvs_q;
	logic [SIDE_W:0]     trial;
	logic [SIDE_W:0]     diff;
	logic                ge;
	logic [SIDE_W-1:0]   next_rem;

	always_comb begin
		trial    = {rem_q, quo_q[PROD_W-1]};
		diff     = trial - {1'b0, dvs_q};
		ge       = (trial >= {1'b0, dvs_q});
		next_rem = ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_W'(PROD_W - 1);
			end else if (busy_q) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], ge};
			rem_q <= next_rem;
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

### src/nnd_setup.sv
// configuration registers and recompute of output size and sampling steps
module nnd_setup #(
	parameter int unsigned MAX_SIDE_LIMIT = nnd_pkg::MAX_SIDE_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnd_pkg::SIDE_W-1:0]    cfg_data,
	output nnd_pkg::geom_t                geom
);
	import nnd_pkg::*;

	localparam logic [SIDE_W+1:0] LIMIT_V = (SIDE_W+2)'(MAX_SIDE_LIMIT);

	function automatic logic [SIDE_W-1:0] clamp_side(
		input logic [SIDE_W-1:0] v,
		input logic              zero_as_one
	);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0 && zero_as_one)
			r = SIDE_W'(1);
		else if ({2'b00, v} > LIMIT_V)
			r = LIMIT_V[SIDE_W-1:0];
		return r;
	endfunction

	setup_state_t state_q, state_d;

	logic [SIDE_W-1:0] src_w_q, src_h_q, max_side_q;
	logic [SIDE_W-1:0] w_q, h_q, lim_q, longer_q;
	logic [PROD_W-1:0] prod_w_q, prod_h_q;
	logic [SIDE_W-1:0] out_w_q, out_h_q;
	logic [SIDE_W-1:0] col_whole_q, col_frac_q, row_whole_q, row_frac_q;

	logic [SIDE_W-1:0] w_c, h_c, lim_c, longer_c;
	logic              byp_c;
	logic              cfg_write;
	logic              cfg_known;

	logic              div_start;
	logic [PROD_W-1:0] div_dividend;
	logic [SIDE_W-1:0] div_divisor;
	logic [PROD_W-1:0] div_quotient;
	logic [SIDE_W-1:0] div_remainder;
	logic              div_done;
	logic [SIDE_W-1:0] quo_side;

	nnd_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quotient),
		.remainder (div_remainder),
		.done      (div_done)
	);

	always_comb begin
		w_c      = clamp_side(src_w_q, 1'b1);
		h_c      = clamp_side(src_h_q, 1'b1);
		lim_c    = clamp_side(max_side_q, 1'b0);
		longer_c = (w_c > h_c) ? w_c : h_c;
		byp_c    = (lim_c == '0) || (longer_c <= lim_c);
		quo_side = div_quotient[SIDE_W-1:0];
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_write = cfg_valid && cfg_ready;
	assign cfg_known = (cfg_index == CFG_SRC_WIDTH) || (cfg_index == CFG_SRC_HEIGHT) ||
		(cfg_index == CFG_MAX_SIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = SIDE_W'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_write && cfg_known)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = byp_c ? ST_IDLE : ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_OW_GO;
			end
			ST_OW_GO: begin
				div_start    = 1'b1;
				div_dividend = prod_w_q;
				div_divisor  = longer_q;
				state_d      = ST_OW_WAIT;
			end
			ST_OW_WAIT: begin
				if (div_done)
					state_d = ST_OH_GO;
			end
			ST_OH_GO: begin
				div_start    = 1'b1;
				div_dividend = prod_h_q;
				div_divisor  = longer_q;
				state_d      = ST_OH_WAIT;
			end
			ST_OH_WAIT: begin
				if (div_done)
					state_d = ST_SW_GO;
			end
			ST_SW_GO: begin
				div_start    = 1'b1;
				div_dividend = PROD_W'(w_q);
				div_divisor  = out_w_q;
				state_d      = ST_SW_WAIT;
			end
			ST_SW_WAIT: begin
				if (div_done)
					state_d = ST_SH_GO;
			end
			ST_SH_GO: begin
				div_start    = 1'b1;
				div_dividend = PROD_W'(h_q);
				div_divisor  = out_h_q;
				state_d      = ST_SH_WAIT;
			end
			ST_SH_WAIT: begin
				if (div_done)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q     <= RST_SRC_WIDTH;
			src_h_q     <= RST_SRC_HEIGHT;
			max_side_q  <= RST_MAX_SIDE;
			w_q         <= SIDE_W'(1);
			h_q         <= SIDE_W'(1);
			out_w_q     <= SIDE_W'(1);
			out_h_q     <= SIDE_W'(1);
			col_whole_q <= SIDE_W'(1);
			col_frac_q  <= '0;
			row_whole_q <= SIDE_W'(1);
			row_frac_q  <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_SRC_WIDTH:  src_w_q    <= cfg_data;
					CFG_SRC_HEIGHT: src_h_q    <= cfg_data;
					CFG_MAX_SIDE:   max_side_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_PREP) begin
				w_q <= w_c;
				h_q <= h_c;
				// pass-through keeps every pixel
				if (byp_c) begin
					out_w_q     <= w_c;
					out_h_q     <= h_c;
					col_whole_q <= SIDE_W'(1);
					col_frac_q  <= '0;
					row_whole_q <= SIDE_W'(1);
					row_frac_q  <= '0;
				end
			end
			if (div_done) begin
				case (state_q)
					ST_OW_WAIT: out_w_q <= (quo_side == '0) ? SIDE_W'(1) : quo_side;
					ST_OH_WAIT: out_h_q <= (quo_side == '0) ? SIDE_W'(1) : quo_side;
					ST_SW_WAIT: begin
						col_whole_q <= quo_side;
						col_frac_q  <= div_remainder;
					end
					ST_SH_WAIT: begin
						row_whole_q <= quo_side;
						row_frac_q  <= div_remainder;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			lim_q    <= lim_c;
			longer_q <= longer_c;
		end
		if (state_q == ST_MUL) begin
			prod_w_q <= PROD_W'(w_q) * PROD_W'(lim_q);
			prod_h_q <= PROD_W'(h_q) * PROD_W'(lim_q);
		end
	end

	always_comb begin
		geom.restart   = cfg_write && cfg_known;
		geom.src_w     = w_q;
		geom.src_h     = h_q;
		geom.out_w     = out_w_q;
		geom.out_h     = out_h_q;
		geom.col_whole = col_whole_q;
		geom.col_frac  = col_frac_q;
		geom.row_whole = row_whole_q;
		geom.row_frac  = row_frac_q;
	end

endmodule

### src/nnd_front.sv
// position tracking: decides per source pixel whether it is kept
module nnd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  nnd_pkg::in_item_t  in_item,
	input  nnd_pkg::geom_t     geom,
	output logic               keep,
	output nnd_pkg::out_item_t out_item
);
	import nnd_pkg::*;

	logic [SIDE_W-1:0] src_col_q, src_row_q, dst_col_q, dst_row_q;
	logic [SIDE_W-1:0] wcol_q, crem_q, wrow_q, rrem_q;

	logic [SIDE_W-1:0] e_src_col, e_src_row, e_dst_col, e_dst_row;
	logic [SIDE_W-1:0] e_wcol, e_crem, e_wrow, e_rrem;
	logic [SIDE_W-1:0] n_src_col, n_src_row, n_dst_col, n_dst_row;
	logic [SIDE_W-1:0] n_wcol, n_crem, n_wrow, n_rrem;
	logic [SIDE_W:0]   csum, rsum, cdiff, rdiff;
	logic              cwrap, rwrap;
	logic              hit, re, fe, last_col, last_row, row_kept;

	always_comb begin
		// frame_start restarts counting on this very pixel
		e_src_col = in_item.frame_start ? '0 : src_col_q;
		e_src_row = in_item.frame_start ? '0 : src_row_q;
		e_dst_col = in_item.frame_start ? '0 : dst_col_q;
		e_dst_row = in_item.frame_start ? '0 : dst_row_q;
		e_wcol    = in_item.frame_start ? '0 : wcol_q;
		e_crem    = in_item.frame_start ? '0 : crem_q;
		e_wrow    = in_item.frame_start ? '0 : wrow_q;
		e_rrem    = in_item.frame_start ? '0 : rrem_q;

		hit = (e_src_row == e_wrow) && (e_src_col == e_wcol) &&
			(e_dst_row < geom.out_h) && (e_dst_col < geom.out_w);
		re  = (({1'b0, e_dst_col} + 1'b1) == {1'b0, geom.out_w});
		fe  = re && (({1'b0, e_dst_row} + 1'b1) == {1'b0, geom.out_h});

		csum  = {1'b0, e_crem} + {1'b0, geom.col_frac};
		cwrap = (csum >= {1'b0, geom.out_w});
		cdiff = csum - {1'b0, geom.out_w};
		rsum  = {1'b0, e_rrem} + {1'b0, geom.row_frac};
		rwrap = (rsum >= {1'b0, geom.out_h});
		rdiff = rsum - {1'b0, geom.out_h};

		last_col = (({1'b0, e_src_col} + 1'b1) >= {1'b0, geom.src_w});
		last_row = (({1'b0, e_src_row} + 1'b1) >= {1'b0, geom.src_h});
		row_kept = (e_src_row == e_wrow);

		n_src_col = e_src_col;
		n_src_row = e_src_row;
		n_dst_col = e_dst_col;
		n_dst_row = e_dst_row;
		n_wcol    = e_wcol;
		n_crem    = e_crem;
		n_wrow    = e_wrow;
		n_rrem    = e_rrem;

		if (hit) begin
			n_dst_col = e_dst_col + SIDE_W'(1);
			n_crem    = cwrap ? cdiff[SIDE_W-1:0] : csum[SIDE_W-1:0];
			n_wcol    = e_wcol + geom.col_whole + SIDE_W'(cwrap);
		end

		if (last_col) begin
			n_src_col = '0;
			n_dst_col = '0;
			n_wcol    = '0;
			n_crem    = '0;
			if (last_row) begin
				n_src_row = '0;
				n_dst_row = '0;
				n_wrow    = '0;
				n_rrem    = '0;
			end else begin
				n_src_row = e_src_row + SIDE_W'(1);
				if (row_kept) begin
					n_dst_row = e_dst_row + SIDE_W'(1);
					n_rrem    = rwrap ? rdiff[SIDE_W-1:0] : rsum[SIDE_W-1:0];
					n_wrow    = e_wrow + geom.row_whole + SIDE_W'(rwrap);
				end
			end
		end else begin
			n_src_col = e_src_col + SIDE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
			wcol_q    <= '0;
			crem_q    <= '0;
			wrow_q    <= '0;
			rrem_q    <= '0;
		end else if (geom.restart) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
			wcol_q    <= '0;
			crem_q    <= '0;
			wrow_q    <= '0;
			rrem_q    <= '0;
		end else if (accept) begin
			src_col_q <= n_src_col;
			src_row_q <= n_src_row;
			dst_col_q <= n_dst_col;
			dst_row_q <= n_dst_row;
			wcol_q    <= n_wcol;
			crem_q    <= n_crem;
			wrow_q    <= n_wrow;
			rrem_q    <= n_rrem;
		end
	end

	assign keep               = accept && hit;
	assign out_item.pixel_out = in_item.pixel_in;
	assign out_item.row_end   = re;
	assign out_item.frame_end = fe;

endmodule

### src/nnd_queue.sv
// short queue of kept items, output side of the block
module nnd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  nnd_pkg::out_item_t wr_item,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output nnd_pkg::out_item_t rd_item
);
	import nnd_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	out_item_t        queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             rd_en;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_en   = pop && !empty;
	assign rd_item = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + CNT_W'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			queue_q[wr_ptr_q] <= wr_item;
	end

endmodule

### src/nearest_neighbor_downscaler.sv
// a kept item enters the result queue when it is accepted and leaves it in order
// throughput: one source item per cycle while the four-entry queue has room and no
// recompute runs; a known register write recomputes sizes in a serial divider and
// holds input off for prep, multiply and 4 divisions, or prep only in pass-through
// reset (async, active low): registers 1, 1, 4096, pass-through geometry, queue empty
module nearest_neighbor_downscaler #(
	parameter int unsigned MAX_SIDE_LIMIT = nnd_pkg::MAX_SIDE_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  nnd_pkg::in_item_t             in_item,
	input  logic                          pop,
	output logic                          empty,
	output nnd_pkg::out_item_t            out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnd_pkg::SIDE_W-1:0]    cfg_data
);
	import nnd_pkg::*;

	geom_t     geom;
	logic      accept;
	logic      keep;
	logic      queue_full;
	out_item_t kept_item;

	nnd_setup #(
		.MAX_SIDE_LIMIT (MAX_SIDE_LIMIT)
	) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	// input waits while the geometry is being recomputed
	assign full   = queue_full || !cfg_ready;
	assign accept = push && !full;

	nnd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_item  (in_item),
		.geom     (geom),
		.keep     (keep),
		.out_item (kept_item)
	);

	nnd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (keep),
		.wr_item (kept_item),
		.pop     (pop),
		.full    (queue_full),
		.empty   (empty),
		.rd_item (out_item)
	);

endmodule

### src/nnd_checker.sv
// port-level checks of the downscaler, bound to the top level
`include "nearest_neighbor_downscaler_defines.svh"

module nnd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic                          pop,
	input logic                          empty,
	input nnd_pkg::out_item_t            out_item,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index
);
	import nnd_pkg::*;

	logic cfg_known_write;
	logic in_taken;

	assign cfg_known_write = cfg_valid && cfg_ready && ((cfg_index == CFG_SRC_WIDTH) ||
		(cfg_index == CFG_SRC_HEIGHT) || (cfg_index == CFG_MAX_SIDE));
	assign in_taken = push && !full;

	// a write to a known register starts a recompute that holds off input
	`NND_ASSERT_NEXT(a_cfg_blocks_input, clk, arst_n, cfg_known_write, full && !cfg_ready)
	`NND_ASSERT_NOW(a_busy_means_full, clk, arst_n, !cfg_ready, full)
	`NND_ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(out_item))
	`NND_ASSERT_NOW(a_frame_end_on_row_end, clk, arst_n, !empty,
		!out_item.frame_end || out_item.row_end)
	// no result without an item going in
	`NND_ASSERT_NEXT(a_no_invented_item, clk, arst_n, empty && !in_taken, empty)

endmodule

bind nearest_neighbor_downscaler nnd_checker u_nnd_checker (.*);

### tb/sv/nearest_neighbor_downscaler_tb.sv
// self-checking testbench of the nearest neighbor downscaler with its own scoreboard
`timescale 1ns / 100ps

module nearest_neighbor_downscaler_tb;
	import nnd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 1400;
	localparam int unsigned CALM_ITEMS   = 200;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned LONG_HOLD    = 120;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	class kept_pixel_board;
		logic [SIDE_W-1:0] reg_width, reg_height, reg_limit;
		logic [SIDE_W-1:0] out_w, out_h, col_whole, col_frac, row_whole, row_frac;
		logic              bypass;
		logic [SIDE_W-1:0] src_col, src_row, dst_col, dst_row;
		logic [SIDE_W-1:0] want_col, col_rem, want_row, row_rem;
		out_item_t         kept_due[$];
		int unsigned       mismatches, kept_checked, row_ends, frame_ends;
		int unsigned       pixels_in, writes, bypass_setups, scaled_setups;

		function int unsigned clamp_side(int unsigned v, bit zero_as_one);
			if (v == 0 && zero_as_one)
				return 1;
			if (v > MAX_SIDE_LIMIT_DEF)
				return MAX_SIDE_LIMIT_DEF;
			return v;
		endfunction

		function void restart();
			src_col = '0; src_row = '0; dst_col = '0; dst_row = '0;
			want_col = '0; col_rem = '0; want_row = '0; row_rem = '0;
		endfunction

		function int unsigned scaled(int unsigned side, int unsigned lim,
				int unsigned longer);
			int unsigned v;
			v = side * lim / longer;
			return (v < 1) ? 1 : v;
		endfunction

		function void recompute();
			int unsigned w, h, lim, longer;
			w = clamp_side(reg_width, 1'b1);
			h = clamp_side(reg_height, 1'b1);
			lim = clamp_side(reg_limit, 1'b0);
			longer = (w > h) ? w : h;
			bypass = (lim == 0) || (longer <= lim);
			if (bypass) begin
				out_w = SIDE_W'(w);
				out_h = SIDE_W'(h);
				bypass_setups++;
			end else begin
				out_w = SIDE_W'(scaled(w, lim, longer));
				out_h = SIDE_W'(scaled(h, lim, longer));
				scaled_setups++;
			end
			col_whole = SIDE_W'(w / out_w);
			col_frac  = SIDE_W'(w % out_w);
			row_whole = SIDE_W'(h / out_h);
			row_frac  = SIDE_W'(h % out_h);
			restart();
		endfunction

		function void power_on();
			reg_width  = RST_SRC_WIDTH;
			reg_height = RST_SRC_HEIGHT;
			reg_limit  = RST_MAX_SIDE;
			recompute();
		endfunction

		function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
			writes++;
			case (idx)
				CFG_SRC_WIDTH:  reg_width = val;
				CFG_SRC_HEIGHT: reg_height = val;
				CFG_MAX_SIDE:   reg_limit = val;
				default:        return;
			endcase
			recompute();
		endfunction

		function int unsigned frame_width();
			return clamp_side(reg_width, 1'b1);
		endfunction

		function int unsigned frame_height();
			return clamp_side(reg_height, 1'b1);
		endfunction

		function int unsigned due_count();
			return kept_due.size();
		endfunction

		function void note_source_pixel(in_item_t px);
			int unsigned w, h;
			out_item_t   due;
			bit          row_kept;
			w = frame_width();
			h = frame_height();
			pixels_in++;
			if (px.frame_start)
				restart();
			if (src_row == want_row && src_col == want_col &&
					dst_row < out_h && dst_col < out_w) begin
				due.pixel_out = px.pixel_in;
				due.row_end   = (dst_col + 1 == out_w);
				due.frame_end = due.row_end && (dst_row + 1 == out_h);
				kept_due = {kept_due, due};
				dst_col++;
				want_col += col_whole;
				col_rem  += col_frac;
				if (col_rem >= out_w) begin
					col_rem -= out_w;
					want_col++;
				end
			end
			if (src_col + 1 >= w) begin
				row_kept = (src_row == want_row);
				src_col = '0; dst_col = '0; want_col = '0; col_rem = '0;
				if (src_row + 1 >= h) begin
					src_row = '0; dst_row = '0; want_row = '0; row_rem = '0;
				end else begin
					src_row++;
					if (row_kept) begin
						dst_row++;
						want_row += row_whole;
						row_rem  += row_frac;
						if (row_rem >= out_h) begin
							row_rem -= out_h;
							want_row++;
						end
					end
				end
			end else begin
				src_col++;
			end
		endfunction

		function void check_kept_pixel(out_item_t got);
			out_item_t due;
			if (kept_due.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: kept pixel %08h/%0b/%0b arrived with nothing due",
						$realtime, got.pixel_out, got.row_end, got.frame_end);
				mismatches++;
				return;
			end
			due = kept_due.pop_front();
			kept_checked++;
			row_ends += got.row_end;
			frame_ends += got.frame_end;
			if (got.pixel_out !== due.pixel_out || got.row_end !== due.row_end ||
					got.frame_end !== due.frame_end) begin
				if (mismatches < 10)
					$display({"%0t: kept pixel %0d: due %08h row_end %0b frame_end %0b,",
						" got %08h %0b %0b"},
						$realtime, kept_checked, due.pixel_out, due.row_end, due.frame_end,
						got.pixel_out, got.row_end, got.frame_end);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	in_item_t             in_item;
	logic                 pop;
	logic                 empty;
	out_item_t            out_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIDE_W-1:0]    cfg_data;

	kept_pixel_board nn_board = new;
	bit              calm;
	bit              tx_bursty;
	bit              long_hold_req;
	int unsigned     random_items;
	int unsigned     cycle_count;

	nearest_neighbor_downscaler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.pop       (pop),
		.empty     (empty),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit start,
			input int unsigned gap);
		in_item_t px;
		px.pixel_in = pix;
		px.frame_start = start;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		in_item <= px;
		@(posedge clk);
		while (full)
			@(posedge clk);
		nn_board.note_source_pixel(px);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		nn_board.apply_register(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every kept pixel is out and the pipeline has flushed dropped ones
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (nn_board.due_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_geometry(input int unsigned w, input int unsigned h,
			input int unsigned lim);
		write_reg(CFG_SRC_WIDTH, SIDE_W'(w));
		write_reg(CFG_SRC_HEIGHT, SIDE_W'(h));
		write_reg(CFG_MAX_SIDE, SIDE_W'(lim));
	endtask

	function automatic int unsigned next_gap();
		if (calm || !tx_bursty)
			return 0;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
	endfunction

	function automatic int unsigned pick_side();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return 0;
		if (roll == 1)
			return $urandom_range(13, 40);
		return $urandom_range(1, 12);
	endfunction

	function automatic int unsigned pick_limit();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 3)
			return 0;
		if (roll < 5)
			return $urandom_range(0, 32767);
		if (roll < 8)
			return $urandom_range(9, 16);
		return $urandom_range(1, 8);
	endfunction

	task automatic run_random_phase();
		int unsigned       w_val, h_val, first, n_frames, n_pix, style, f, p, k;
		logic [SIDE_W-1:0] reg_val[3];
		w_val = pick_side();
		h_val = (w_val > 12) ? $urandom_range(1, 3) : pick_side();
		reg_val[0] = SIDE_W'(w_val);
		reg_val[1] = SIDE_W'(h_val);
		reg_val[2] = SIDE_W'(pick_limit());
		first = $urandom_range(0, 2);
		for (k = 0; k < 3; k++)
			write_reg(CFG_IDX_W'((first + k) % 3), reg_val[(first + k) % 3]);
		if ($urandom_range(0, 7) == 0)
			write_reg(CFG_UNUSED, SIDE_W'($urandom_range(0, 32767)));
		tx_bursty = ($urandom_range(0, 3) != 0);
		n_frames = $urandom_range(1, 3);
		for (f = 0; f < n_frames; f++) begin
			style = $urandom_range(0, 9);
			n_pix = nn_board.frame_width() * nn_board.frame_height();
			// cut short: the next frame start abandons this one
			if (style == 7)
				n_pix = $urandom_range(1, n_pix);
			for (p = 0; p < n_pix; p++) begin
				// no frame start at all: the counters wrap from the previous frame
				send_pixel($urandom, (p == 0 && style != 8) ||
					(style == 9 && $urandom_range(0, 7) == 0), next_gap());
				random_items++;
				if (random_items >= RANDOM_ITEMS - CALM_ITEMS)
					calm = 1'b1;
			end
		end
		drain();
	endtask

	// result side: random stalls, quiet stretches and one long hold-off on request
	initial begin
		int unsigned hold_left;
		bit          rx_quiet;
		hold_left = 0;
		rx_quiet = 1'b0;
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				rx_quiet = !rx_quiet;
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				pop <= 1'b0;
			end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 8);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			nn_board.check_kept_pixel(out_item);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped after %0d cycles", cycle_count);
		$display("nearest_neighbor_downscaler: mismatch");
		$finish;
	end

	initial begin
		int unsigned p;
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		tx_bursty = 1'b0;
		long_hold_req = 1'b0;
		random_items = 0;
		nn_board.power_on();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset geometry is 1x1 pass-through: every item ends a frame
		send_pixel(32'h0000_0000, 1'b1, 0);
		send_pixel(32'hFFFF_FFFF, 1'b0, 0);
		send_pixel($urandom, 1'b1, 0);
		drain();

		// oversized width saturates; early frame start re-keeps column zero
		set_geometry(32767, 3, 2);
		send_pixel($urandom, 1'b1, 0);
		send_pixel($urandom, 1'b0, 0);
		send_pixel($urandom, 1'b1, 0);
		send_pixel($urandom, 1'b0, 0);
		drain();

		// zero width taken as one, limit saturates to the largest side
		set_geometry(0, 16384, 32767);
		for (p = 0; p < 3; p++)
			send_pixel($urandom, p == 0, 0);
		drain();

		// limit zero passes through; the seventh item overruns into a new frame
		set_geometry(3, 2, 0);
		write_reg(CFG_UNUSED, 15'h5A5A);
		for (p = 0; p < 7; p++)
			send_pixel($urandom, p == 0, 0);
		drain();

		// receiver holds off long enough for the result queue to fill and stall input
		set_geometry(8, 4, 0);
		long_hold_req = 1'b1;
		for (p = 0; p < 32; p++)
			send_pixel($urandom, p == 0, 0);
		drain();

		while (random_items < RANDOM_ITEMS)
			run_random_phase();
		drain();

		$display("covered %0d source items, %0d register writes",
			nn_board.pixels_in, nn_board.writes);
		$display({"setups: %0d pass-through, %0d scaled; checked %0d kept items with",
			" %0d row ends and %0d frame ends, one long output stall"},
			nn_board.bypass_setups, nn_board.scaled_setups,
			nn_board.kept_checked, nn_board.row_ends, nn_board.frame_ends);
		if (nn_board.mismatches == 0 && nn_board.due_count() == 0) begin
			$display("nearest_neighbor_downscaler: match");
		end else begin
			$display("%0d mismatches", nn_board.mismatches);
			$display("nearest_neighbor_downscaler: mismatch");
		end
		$finish;
	end

endmodule
